// ===== hdl/ntx_pkg.sv =====
// Shared types and constants for the newline normalize / tab expand block.
// Used by ntx_ctrl, ntx_datapath and the top level.
package ntx_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int         TAB_CFG_W       = 5;
    localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;
    // width used to clamp the tab width against the largest tab stop spacing
    localparam int         CLAMP_W         = 7;

    typedef enum logic {
        ST_IDLE,
        ST_TAB
    } t_state;

    typedef struct packed {
        logic take_in;     // input transaction this cycle
        logic load_space;  // load next space of a tab run
        logic reduce;      // fold column back below the tab width
    } t_cmd;

    typedef struct packed {
        logic col_ge_w;    // stored column not below current tab width
        logic out_free;    // output register empty or being drained
        logic tab_multi;   // incoming byte is a tab needing more than one space
        logic rem_one;     // one space left in the current tab run
    } t_status;

endpackage

// ===== hdl/ntx_ctrl.sv =====
// Controller for the normalizer: idle / tab-run sequencing, input ready.
// Depends on ntx_pkg for the state enum and command/status structs.
module ntx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  ntx_pkg::t_status i_status,
    output logic             o_ready,
    output ntx_pkg::t_cmd    o_cmd,
    output ntx_pkg::t_state  o_state
);
    import ntx_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.take_in && i_status.tab_multi) begin
                    n_state = ST_TAB;
                end
            end
            ST_TAB: begin
                if (i_status.out_free && i_status.rem_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_cmd.take_in    = 1'b0;
        o_cmd.load_space = 1'b0;
        o_cmd.reduce     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready       = !i_status.col_ge_w && i_status.out_free;
                o_cmd.take_in = i_s_tvalid && o_ready;
                o_cmd.reduce  = i_status.col_ge_w;
            end
            ST_TAB: begin
                o_cmd.load_space = i_status.out_free;
            end
            default: o_ready = 1'b0;
        endcase
    end

    assign o_state = r_state;

endmodule

// ===== hdl/ntx_datapath.sv =====
// Datapath: tab width register, column/CR/sticky state, space counter,
// output register. Depends on ntx_pkg for character codes and structs.
module ntx_datapath #(
    parameter int MAX_TAB_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ntx_pkg::TAB_CFG_W-1:0]    i_cfg_wdata,
    input  logic [7:0]                       i_s_tdata,
    input  logic                             i_s_tlast,
    input  ntx_pkg::t_cmd                    i_cmd,
    input  logic                             i_m_tready,
    output ntx_pkg::t_status                 o_status,
    output logic                             o_m_tvalid,
    output logic [7:0]                       o_m_tdata,
    output logic                             o_m_tlast,
    output logic                             o_m_tuser
);
    import ntx_pkg::*;

    localparam int CW = $clog2(MAX_TAB_WIDTH);
    localparam int WW = $clog2(MAX_TAB_WIDTH + 1);
    localparam logic [CLAMP_W-1:0] MAX_W = CLAMP_W'(MAX_TAB_WIDTH);

    logic [TAB_CFG_W-1:0] r_tw;
    logic [CW-1:0]        r_col;
    logic                 r_cr;
    logic                 r_changed;
    logic [CW-1:0]        r_rem;
    logic                 r_ovalid;
    logic [7:0]           r_obyte;
    logic                 r_olast;
    logic                 r_ochg;

    logic [CLAMP_W-1:0] tw_ext;
    logic [CLAMP_W-1:0] w_clamp;
    logic [WW-1:0]      w;
    logic [WW-1:0]      col_ext;
    logic [WW-1:0]      col_inc;
    logic [WW-1:0]      spaces;
    logic [CW-1:0]      n_col;
    logic               is_cr;
    logic               is_lf;
    logic               is_tab;
    logic               has_result;
    logic               load_out;
    logic [7:0]         res_byte;
    logic               res_last;
    logic               res_chg;

    always_comb begin
        tw_ext = CLAMP_W'(r_tw);
        priority if (tw_ext == '0) begin
            w_clamp = CLAMP_W'(1);
        end else if (tw_ext > MAX_W) begin
            w_clamp = MAX_W;
        end else begin
            w_clamp = tw_ext;
        end
    end

    assign w       = w_clamp[WW-1:0];
    assign col_ext = WW'(r_col);
    assign col_inc = col_ext + WW'(1);
    assign spaces  = w - col_ext;

    assign is_cr  = (i_s_tdata == CH_CR);
    assign is_lf  = (i_s_tdata == CH_LF);
    assign is_tab = (i_s_tdata == CH_TAB);
    // LF straight after CR yields nothing
    assign has_result = !(is_lf && r_cr);

    always_comb begin
        res_chg = r_changed || is_cr || is_tab;
        if (is_cr || is_lf) begin
            res_byte = CH_LF;
            res_last = 1'b1;
        end else if (is_tab) begin
            res_byte = CH_SPACE;
            res_last = (spaces == WW'(1));
        end else begin
            res_byte = i_s_tdata;
            res_last = 1'b1;
        end
    end

    always_comb begin
        if (is_cr || is_lf || is_tab || (col_inc == w)) begin
            n_col = '0;
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    assign load_out = (i_cmd.take_in && has_result) || i_cmd.load_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw      <= TAB_WIDTH_RESET;
            r_col     <= '0;
            r_cr      <= 1'b0;
            r_changed <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tw <= i_cfg_wdata;
            end
            if (i_cmd.take_in) begin
                if (i_s_tlast) begin
                    r_col     <= '0;
                    r_cr      <= 1'b0;
                    r_changed <= 1'b0;
                end else begin
                    r_col     <= n_col;
                    r_cr      <= is_cr;
                    r_changed <= res_chg;
                end
            end else if (i_cmd.reduce) begin
                r_col <= r_col - w[CW-1:0];
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_rem <= CW'(spaces - WW'(1));
        end else if (i_cmd.load_space) begin
            r_rem <= r_rem - CW'(1);
        end
        if (i_cmd.take_in) begin
            r_obyte <= res_byte;
            r_olast <= res_last;
            r_ochg  <= res_chg;
        end else if (i_cmd.load_space) begin
            r_obyte <= CH_SPACE;
            r_olast <= (r_rem == CW'(1));
            r_ochg  <= 1'b1;
        end
    end

    assign o_status.col_ge_w  = (col_ext >= w);
    assign o_status.out_free  = !r_ovalid || i_m_tready;
    assign o_status.tab_multi = is_tab && (spaces != WW'(1));
    assign o_status.rem_one   = (r_rem == CW'(1));

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ochg;

endmodule

// ===== hdl/newline_normalize_tab_expand.sv =====
// Top level of the newline normalize / tab expand stream block.
// Instantiates ntx_ctrl and ntx_datapath; uses ntx_pkg.
//
// Turns a text byte stream into one with LF line endings and tabs expanded
// to spaces. CR becomes LF, an LF right after a CR is dropped, and a tab
// becomes enough spaces to reach the next tab stop (tab width from the
// configuration register, 0 acting as 1, clamped to MAX_TAB_WIDTH). Every
// byte other than a tab yields at most one output transaction; a tab holds
// the input until each space it produces has been loaded into the single
// output register, which the space counter refills. After a tab width
// change the stored column is folded below the new width by repeated
// subtraction before the next byte is taken. tlast on the output marks
// the last byte produced by one input byte and tuser is the sticky CR/tab
// flag of the stream; column and flags restart after an input byte with
// tlast set.
module newline_normalize_tab_expand #(
    parameter int MAX_TAB_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ntx_pkg::TAB_CFG_W-1:0] i_cfg_wdata,  // tab_width
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,    // [7:0] in_byte
    input  logic                          i_s_tlast,    // in_last
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,    // [7:0] out_byte
    output logic                          o_m_tlast,    // run_last
    output logic                          o_m_tuser     // [0] stream_changed
);
    import ntx_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_state  w_state;

    ntx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_ready    (o_s_tready),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    ntx_datapath #(
        .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_cmd       (w_cmd),
        .i_m_tready  (i_m_tready),
        .o_status    (w_status),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

`ifndef SYNTH
    // a space is always pending while a tab run is in progress
    a_tab_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_TAB) |-> o_m_tvalid)
        else $error("tab run without pending output");

    // no input transaction while spaces are still being produced
    a_tab_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_TAB) |-> !o_s_tready)
        else $error("input ready during tab run");

    // a non-final output of a run is followed right away by the next one
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("run broken before its last byte");
`endif

endmodule
